// File: hw/rtl/chs_pkg.sv
package chs_pkg;

  // table geometry
  localparam int BUCKETS      = 64;
  localparam int BUCKET_DEPTH = 8;
  localparam int SLOTS        = BUCKETS * BUCKET_DEPTH;
  localparam int BKT_W        = $clog2(BUCKETS);
  localparam int SLOT_W       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int ADDR_W       = $clog2(SLOTS);
  localparam int KEY_W        = 32;
  localparam int TSIZE_W      = 7;
  localparam int MOD_W        = $clog2(BUCKETS + 1);
  localparam int DIV_CNT_W    = $clog2(KEY_W);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // register map
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST = TSIZE_W'(BUCKETS);

  typedef struct packed {
    logic [1:0]        command;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] bucket;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       fix;
    logic       row_rd;
    logic       ins_commit;
    logic       key_rd;
    logic       del_commit;
    logic       slot_inc;
    logic       st_we;
    logic [1:0] st_code;
    logic       res_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic is_insert;
    logic is_delete;
    logic has_free;
    logic hit;
    logic slot_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/chs_ctrl.sv
module chs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chs_pkg::dp_sts_t sts,
  output chs_pkg::dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_FIX  = 8'b0000_0100,
    S_ROW  = 8'b0000_1000,
    S_ROWW = 8'b0001_0000,
    S_SRD  = 8'b0010_0000,
    S_SCMP = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_ROWW;
      end
      S_ROWW: begin
        if (sts.is_insert) begin
          cmd.st_we = 1'b1;
          if (sts.has_free) begin
            cmd.ins_commit = 1'b1;
            cmd.st_code    = chs_pkg::ST_OK;
          end else begin
            cmd.st_code = chs_pkg::ST_FULL;
          end
          state_nxt = S_RES;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.key_rd = 1'b1;
        state_nxt  = S_SCMP;
      end
      S_SCMP: begin
        if (sts.hit) begin
          cmd.st_we      = 1'b1;
          cmd.st_code    = chs_pkg::ST_OK;
          cmd.del_commit = sts.is_delete;
          state_nxt      = S_RES;
        end else if (sts.slot_last) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = chs_pkg::ST_ABSENT;
          state_nxt   = S_RES;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_SRD;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/chs_dp.sv
module chs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chs_pkg::in_word_t            in_data,
  input  logic [chs_pkg::MOD_W-1:0]    modulus,
  input  chs_pkg::dp_cmd_t             cmd,
  output chs_pkg::dp_sts_t             sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output chs_pkg::out_word_t           out_data
);

  localparam int DEPTH = chs_pkg::BUCKET_DEPTH;

  // stores: keys undefined until written, occupancy rows gated by row-valid flops
  logic [chs_pkg::KEY_W-1:0] key_mem [chs_pkg::SLOTS];
  logic [DEPTH-1:0]          row_mem [chs_pkg::BUCKETS];
  logic [chs_pkg::BUCKETS-1:0] row_ok_r;

  logic [1:0]                       op_r;
  logic [chs_pkg::KEY_W-1:0]        key_r;
  logic                             neg_r;
  logic [chs_pkg::KEY_W-1:0]        dvd_r;
  logic [chs_pkg::MOD_W-1:0]        rem_r;
  logic [chs_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [chs_pkg::BKT_W-1:0]        bucket_r;
  logic [chs_pkg::SLOT_W-1:0]       slot_r;
  logic [DEPTH-1:0]                 row_q;
  logic                             row_ok_q;
  logic [chs_pkg::KEY_W-1:0]        key_q;
  logic [1:0]                       status_r;
  logic                             out_valid_r;
  chs_pkg::out_word_t               out_r;

  logic [chs_pkg::KEY_W-1:0]        key_abs;
  logic [chs_pkg::MOD_W:0]          trial;
  logic [chs_pkg::MOD_W:0]          trial_sub;
  logic [chs_pkg::MOD_W-1:0]        rem_nxt;
  logic [chs_pkg::MOD_W-1:0]        bucket_nxt;
  logic [DEPTH-1:0]                 row_eff;
  logic [chs_pkg::SLOT_W-1:0]       free_slot;
  logic [DEPTH-1:0]                 free_onehot;
  logic [DEPTH-1:0]                 slot_onehot;
  logic [chs_pkg::ADDR_W-1:0]       row_base;
  logic [chs_pkg::ADDR_W-1:0]       ins_addr;
  logic [chs_pkg::ADDR_W-1:0]       rd_addr;

  // magnitude of the key, wraps correctly for the most negative value
  assign key_abs = in_data.key[chs_pkg::KEY_W-1] ? (~in_data.key + 1'b1) : in_data.key;

  // one restoring step of the remainder
  assign trial     = {rem_r, dvd_r[chs_pkg::KEY_W-1]};
  assign trial_sub = trial - {1'b0, modulus};
  assign rem_nxt   = (trial >= {1'b0, modulus}) ? trial_sub[chs_pkg::MOD_W-1:0]
                                                : trial[chs_pkg::MOD_W-1:0];

  // negative keys with a nonzero remainder fold up to m - r
  assign bucket_nxt = (neg_r && (rem_r != '0)) ? (modulus - rem_r) : rem_r;

  // occupancy row of the current bucket, empty if never written
  assign row_eff = row_ok_q ? row_q : '0;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!row_eff[i]) begin
        free_slot = chs_pkg::SLOT_W'(i);
      end
    end
  end

  assign free_onehot = DEPTH'(1) << free_slot;
  assign slot_onehot = DEPTH'(1) << slot_r;

  assign row_base = chs_pkg::ADDR_W'(bucket_r) * chs_pkg::ADDR_W'(DEPTH);
  assign ins_addr = row_base + chs_pkg::ADDR_W'(free_slot);
  assign rd_addr  = row_base + chs_pkg::ADDR_W'(slot_r);

  // working registers of one word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.command;
      key_r  <= in_data.key;
      neg_r  <= in_data.key[chs_pkg::KEY_W-1];
      dvd_r  <= key_abs;
      rem_r  <= '0;
      cnt_r  <= '0;
      slot_r <= '0;
    end else begin
      if (cmd.div_step) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[chs_pkg::KEY_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.slot_inc) begin
        slot_r <= slot_r + 1'b1;
      end
    end
    if (cmd.fix) begin
      bucket_r <= bucket_nxt[chs_pkg::BKT_W-1:0];
    end
    if (cmd.st_we) begin
      status_r <= cmd.st_code;
    end
  end

  // key store
  always_ff @(posedge clk) begin
    if (cmd.ins_commit) begin
      key_mem[ins_addr] <= key_r;
    end
    if (cmd.key_rd) begin
      key_q <= key_mem[rd_addr];
    end
  end

  // occupancy rows
  always_ff @(posedge clk) begin
    if (cmd.ins_commit) begin
      row_mem[bucket_r] <= row_eff | free_onehot;
    end else if (cmd.del_commit) begin
      row_mem[bucket_r] <= row_eff & ~slot_onehot;
    end
    if (cmd.row_rd) begin
      row_q <= row_mem[bucket_r];
    end
  end

  // row-valid flops, cleared at reset so the table starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      row_ok_q <= 1'b0;
    end else begin
      if (cmd.ins_commit || cmd.del_commit) begin
        row_ok_r[bucket_r] <= 1'b1;
      end
      if (cmd.row_rd) begin
        row_ok_q <= row_ok_r[bucket_r];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.status <= status_r;
      out_r.bucket <= 6'(bucket_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to the controller
  assign sts.div_last  = (cnt_r == chs_pkg::DIV_CNT_W'(chs_pkg::KEY_W - 1));
  assign sts.is_insert = (op_r == chs_pkg::CMD_INSERT);
  assign sts.is_delete = (op_r == chs_pkg::CMD_DELETE);
  assign sts.has_free  = ~&row_eff;
  assign sts.hit       = row_eff[slot_r] && (key_q == key_r);
  assign sts.slot_last = (slot_r == chs_pkg::SLOT_W'(DEPTH - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// File: hw/rtl/chained_hash_set.sv
// Hash set of signed 32-bit keys in 64 buckets of 8 slots each. Each input word is an
// insert, delete or search; each gives one result word with a status (ok or found,
// not present, bucket full) and the bucket of the key, the non-negative remainder of
// the key modulo table_size (held to 1..64). Words are handled one at a time: a
// bit-serial remainder over the key bits, then fixing the bucket and reading its
// occupancy row, then for delete and search one key memory read and one compare per
// slot probed, and last the load of the result register; the next word is taken
// only after that load. A result left waiting holds the next word back. The table is
// empty after reset with no clearing pass; table_size sits at byte address 0 and
// resets to 64.
module chained_hash_set (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chs_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chs_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [chs_pkg::TSIZE_W-1:0] table_size_r;
  logic [chs_pkg::MOD_W-1:0]   modulus;
  logic                        reg_sel;
  chs_pkg::dp_cmd_t            cmd;
  chs_pkg::dp_sts_t            sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == chs_pkg::REG_TABLE_SIZE);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= chs_pkg::TABLE_SIZE_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      table_size_r <= pwdata[chs_pkg::TSIZE_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(table_size_r) : '0;

  // saturate the modulus to 1..BUCKETS
  always_comb begin
    if (table_size_r == '0) begin
      modulus = chs_pkg::MOD_W'(1);
    end else if (table_size_r > chs_pkg::TSIZE_W'(chs_pkg::BUCKETS)) begin
      modulus = chs_pkg::MOD_W'(chs_pkg::BUCKETS);
    end else begin
      modulus = chs_pkg::MOD_W'(table_size_r);
    end
  end

  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .modulus   (modulus),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/chs_checker.sv
module chs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input chs_pkg::out_word_t out_data,
  input logic               out_valid,
  input logic               out_ready,
  input logic               pready
);

  // a stalled result holds its word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

  // only defined status codes leave the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == chs_pkg::ST_OK ||
                   out_data.status == chs_pkg::ST_ABSENT ||
                   out_data.status == chs_pkg::ST_FULL))
    else $error("undefined status code");

  // reset drops any pending result
  assert property (@(posedge clk) !rst_n |=> !out_valid && pready)
    else $error("result pending after reset");

endmodule

bind chained_hash_set chs_checker u_chs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pready    (pready)
);
